// ===== rtl/core/fcpa_pkg.sv =====
// Shared types and constants for the fixed chunk pool allocator.
`timescale 1ns / 1ps

package fcpa_pkg;

  localparam int MAX_CHUNKS_DEF = 1024;

  localparam int BASE_W  = 32;
  localparam int SHIFT_W = 4;
  localparam int COUNT_W = 11;

  localparam logic [SHIFT_W-1:0] SHIFT_LIMIT = 4'd12;

  localparam logic [BASE_W-1:0]  RST_BASE  = 32'd0;
  localparam logic [SHIFT_W-1:0] RST_SHIFT = 4'd4;
  localparam logic [COUNT_W-1:0] RST_COUNT = 11'd256;

  localparam logic [1:0] CFG_BASE  = 2'd0;
  localparam logic [1:0] CFG_SHIFT = 2'd1;
  localparam logic [1:0] CFG_COUNT = 2'd2;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_REJECT = 2'd2
  } status_t;

  typedef struct packed {
    logic clr;   // clearing pass over the allocated map
    logic load;  // capture input beat
    logic rd;    // issue memory reads
    logic wr;    // commit update and load result
  } fcpa_cmd_t;

  typedef struct packed {
    logic clr_done;
  } fcpa_sts_t;

endpackage

// ===== rtl/core/fcpa_ctrl.sv =====
// Controller state machine for the fixed chunk pool allocator.
`timescale 1ns / 1ps

module fcpa_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  logic               out_tready,
  output fcpa_pkg::fcpa_cmd_t cmd,
  input  fcpa_pkg::fcpa_sts_t sts
);
  import fcpa_pkg::*;

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_READ, S_WRITE} state_t;

  state_t st_r, st_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   can_fin;

  always_comb begin
    can_fin   = !out_valid_r || out_tready;
    in_tready = (st_r == S_IDLE) || (st_r == S_WRITE && can_fin);
    cmd.clr   = (st_r == S_CLEAR);
    cmd.load  = in_tvalid && in_tready;
    cmd.rd    = (st_r == S_READ);
    cmd.wr    = (st_r == S_WRITE) && can_fin;

    st_nxt = st_r;
    unique case (st_r)
      S_CLEAR: if (sts.clr_done) st_nxt = S_IDLE;
      S_IDLE:  if (in_tvalid) st_nxt = S_READ;
      S_READ:  st_nxt = S_WRITE;
      S_WRITE: begin
        if (can_fin) st_nxt = in_tvalid ? S_READ : S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase

    out_valid_nxt = out_valid_r;
    if (cmd.wr) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

  a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (st_r == S_READ))
    else $error("accepted beat not followed by read");

  a_wr_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr |-> (!out_valid_r || out_tready))
    else $error("result written over pending beat");

  a_wr_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr |=> out_valid_r)
    else $error("result not presented after commit");

endmodule

// ===== rtl/core/fcpa_dpath.sv =====
// Datapath for the fixed chunk pool allocator: config, free stack, allocated map.
`timescale 1ns / 1ps

module fcpa_dpath #(
  parameter int MAX_CHUNKS = fcpa_pkg::MAX_CHUNKS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [fcpa_pkg::BASE_W-1:0]   cfg_wdata,
  input  logic                          in_mode,
  input  logic [fcpa_pkg::BASE_W-1:0]   in_addr,
  output logic [fcpa_pkg::BASE_W-1:0]   out_addr,
  output fcpa_pkg::status_t             out_status,
  input  fcpa_pkg::fcpa_cmd_t           cmd,
  output fcpa_pkg::fcpa_sts_t           sts
);
  import fcpa_pkg::*;

  localparam int IW = $clog2(MAX_CHUNKS);
  localparam int CW = $clog2(MAX_CHUNKS + 1);

  // configuration
  logic [BASE_W-1:0]  base_r;
  logic [SHIFT_W-1:0] shift_r;
  logic [COUNT_W-1:0] count_r;

  // captured request
  logic              mode_r;
  logic [BASE_W-1:0] addr_r;

  // pool state
  logic [CW-1:0] fc_r;       // free stack depth
  logic [CW-1:0] lw_r;       // low-water mark; entries below it still hold their own index
  logic          started_r;
  logic [IW-1:0] clr_r;

  // lookup results
  logic [IW-1:0] idx_r;
  logic          bad_r;
  logic [IW-1:0] stk_rd_r;
  logic          map_rd_r;

  logic [IW-1:0] stk_mem [MAX_CHUNKS];
  logic          map_mem [MAX_CHUNKS];

  logic [BASE_W-1:0] out_addr_r;
  status_t           out_status_r;

  logic [SHIFT_W-1:0] shift_eff;
  logic [CW-1:0]      cnt_eff;
  logic [CW-1:0]      fc_eff;
  logic [CW-1:0]      fc_dec;
  logic [BASE_W-1:0]  offset;
  logic [BASE_W-1:0]  idx_full;
  logic [BASE_W-1:0]  mask;
  logic               bad;
  logic [CW-1:0]      pos;
  logic               empty;
  logic [IW-1:0]      pidx;
  logic               free_ok;
  logic               stk_we;
  logic               map_we;
  logic [IW-1:0]      map_waddr;
  logic               map_wdata;

  always_comb begin
    shift_eff = (shift_r > SHIFT_LIMIT) ? SHIFT_LIMIT : shift_r;
    cnt_eff   = ({21'd0, count_r} > 32'(MAX_CHUNKS)) ? CW'(MAX_CHUNKS) : CW'(count_r);
    fc_eff    = started_r ? fc_r : cnt_eff;
    fc_dec    = fc_eff - CW'(1);
    offset    = addr_r - base_r;
    idx_full  = offset >> shift_eff;
    mask      = (32'd1 << shift_eff) - 32'd1;
    bad       = (|(offset & mask)) || (idx_full >= 32'(cnt_eff));

    pos     = fc_r - CW'(1);
    empty   = (fc_r == '0);
    pidx    = (pos < lw_r) ? pos[IW-1:0] : stk_rd_r;
    free_ok = !bad_r && map_rd_r;

    stk_we    = cmd.wr && (mode_r == MODE_FREE) && free_ok && (fc_r != CW'(MAX_CHUNKS));
    map_we    = cmd.wr && ((mode_r == MODE_FREE) ? free_ok : !empty);
    map_waddr = (mode_r == MODE_FREE) ? idx_r : pidx;
    map_wdata = (mode_r == MODE_ALLOC);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r    <= RST_BASE;
      shift_r   <= RST_SHIFT;
      count_r   <= RST_COUNT;
      fc_r      <= '0;
      lw_r      <= '0;
      started_r <= 1'b0;
      clr_r     <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_BASE:  base_r  <= cfg_wdata;
          CFG_SHIFT: shift_r <= cfg_wdata[SHIFT_W-1:0];
          CFG_COUNT: count_r <= cfg_wdata[COUNT_W-1:0];
          default: ;
        endcase
      end
      if (cmd.clr) clr_r <= clr_r + IW'(1);
      if (cmd.rd) begin
        fc_r      <= fc_eff;
        lw_r      <= started_r ? lw_r : cnt_eff;
        started_r <= 1'b1;
      end
      if (cmd.wr) begin
        if (mode_r == MODE_ALLOC) begin
          if (!empty) begin
            fc_r <= pos;
            if (pos < lw_r) lw_r <= pos;
          end
        end else if (stk_we) begin
          fc_r <= fc_r + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= in_mode;
      addr_r <= in_addr;
    end
    if (cmd.rd) begin
      idx_r    <= idx_full[IW-1:0];
      bad_r    <= bad;
      stk_rd_r <= stk_mem[fc_dec[IW-1:0]];
      map_rd_r <= map_mem[idx_full[IW-1:0]];
    end
    if (cmd.wr) begin
      if (mode_r == MODE_ALLOC) begin
        out_addr_r   <= empty ? '0 : base_r + (32'(pidx) << shift_eff);
        out_status_r <= empty ? ST_EMPTY : ST_OK;
      end else begin
        out_addr_r   <= '0;
        out_status_r <= free_ok ? ST_OK : ST_REJECT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stk_we) stk_mem[fc_r[IW-1:0]] <= idx_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.clr) map_mem[clr_r] <= 1'b0;
    else if (map_we) map_mem[map_waddr] <= map_wdata;
  end

  assign sts.clr_done = (clr_r == IW'(MAX_CHUNKS - 1));
  assign out_addr     = out_addr_r;
  assign out_status   = out_status_r;

  a_fc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    started_r |-> (fc_r <= CW'(MAX_CHUNKS)))
    else $error("free stack depth beyond pool size");

  a_lw_below_fc: assert property (@(posedge clk) disable iff (!rst_n)
    started_r |-> (lw_r <= fc_r))
    else $error("low-water mark above stack depth");

endmodule

// ===== rtl/core/fixed_chunk_pool_allocator.sv =====
// Each request reads the free stack and allocated map in the read state, then
//   updates them and registers its result in the write state once the output
//   register is free; a new one is accepted while idle or with that update.
// Reset: synchronous, active low; afterwards a clearing pass zeroes every entry
//   of the allocated map, with in_tready low. Config writes are taken.
// Top level of the fixed chunk pool allocator.
`timescale 1ns / 1ps

module fixed_chunk_pool_allocator #(
  parameter int MAX_CHUNKS = fcpa_pkg::MAX_CHUNKS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] free_address
  input  logic [0:0]  in_tuser,   // [0] mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] chunk_address
  output logic [1:0]  out_tuser   // [1:0] status
);
  import fcpa_pkg::*;

  fcpa_cmd_t cmd;
  fcpa_sts_t sts;
  status_t   status;

  fcpa_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  fcpa_dpath #(
    .MAX_CHUNKS (MAX_CHUNKS)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_mode    (in_tuser[0]),
    .in_addr    (in_tdata),
    .out_addr   (out_tdata),
    .out_status (status),
    .cmd        (cmd),
    .sts        (sts)
  );

  assign out_tuser = status;

endmodule

// ===== tb/fixed_chunk_pool_allocator_test.sv =====
// Self-checking testbench for the fixed chunk pool allocator: random and directed requests.
`timescale 1ns / 1ps

module fixed_chunk_pool_allocator_test;
  import fcpa_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 8;

  typedef struct packed {
    logic        mode;
    logic [31:0] addr;
  } req_t;

  typedef struct {
    logic [31:0] addr;
    status_t     st;
  } grant_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_BASE;
  logic [31:0] cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;   // [31:0] free_address
  logic [0:0]  in_tuser = '0;   // [0] mode
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;       // [31:0] chunk_address
  logic [1:0]  out_tuser;       // [1:0] status

  fixed_chunk_pool_allocator i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // register shadow
  logic [31:0] r_base  = RST_BASE;
  logic [3:0]  r_shift = RST_SHIFT;
  logic [10:0] r_count = RST_COUNT;

  // pool state as the block should hold it
  logic [9:0]  spare_idx [0:MAX_CHUNKS_DEF-1];
  int unsigned spare_n = 0;
  bit          pool_open = 1'b0;
  bit          in_use [0:MAX_CHUNKS_DEF-1];
  int unsigned live_chunks [$];

  req_t   request_q [$];
  grant_t grant_q [$];
  req_t   on_bus;
  grant_t seen;

  bit src_idle_on = 1'b1;
  bit snk_idle_on = 1'b1;
  bit hold_req = 1'b0;
  int src_gap = 0;
  int snk_wait = 0;
  int quiet_cycles = 0;

  int n_granted = 0;
  int n_empty = 0;
  int n_returned = 0;
  int n_rejected = 0;
  int n_checked = 0;
  int mismatches = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int unsigned eff_shift();
    return (r_shift > SHIFT_LIMIT) ? 32'(SHIFT_LIMIT) : 32'(r_shift);
  endfunction

  function automatic int unsigned eff_count();
    return (r_count > MAX_CHUNKS_DEF) ? MAX_CHUNKS_DEF : r_count;
  endfunction

  function automatic logic [31:0] slot(input int unsigned idx);
    return r_base + (32'(idx) << eff_shift());
  endfunction

  function automatic int pick_gap();
    int k;
    k = $urandom_range(0, 99);
    if (k < 50) return 0;
    if (k < 85) return $urandom_range(1, 3);
    if (k < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // one accepted request: update the pool and queue the reply it must give
  function automatic void predict_grant(input req_t r);
    int unsigned sh;
    int unsigned cnt;
    int unsigned idx;
    logic [31:0] off;
    logic [31:0] msk;
    int hits [$];
    grant_t g;
    sh = eff_shift();
    cnt = eff_count();
    g.addr = '0;
    g.st = ST_OK;
    if (!pool_open) begin
      for (int i = 0; i < cnt; i++) spare_idx[i] = 10'(i);
      spare_n = cnt;
      pool_open = 1'b1;
    end
    if (r.mode == MODE_ALLOC) begin
      if (spare_n == 0) begin
        g.st = ST_EMPTY;
        n_empty++;
      end else begin
        spare_n--;
        idx = spare_idx[spare_n];
        in_use[idx] = 1'b1;
        live_chunks = {live_chunks, idx};
        g.addr = r_base + (32'(idx) << sh);
        n_granted++;
      end
    end else begin
      off = r.addr - r_base;
      msk = (32'd1 << sh) - 32'd1;
      idx = off >> sh;
      if ((off & msk) != 0 || idx >= cnt || !in_use[idx]) begin
        g.st = ST_REJECT;
        n_rejected++;
      end else begin
        in_use[idx] = 1'b0;
        hits = live_chunks.find_first_index(item) with (item == idx);
        if (hits.size() != 0) live_chunks.delete(hits[0]);
        if (spare_n < MAX_CHUNKS_DEF) begin
          spare_idx[spare_n] = 10'(idx);
          spare_n++;
        end
        n_returned++;
      end
    end
    grant_q = {grant_q, g};
  endfunction

  function automatic logic [31:0] pick_free_addr();
    int k;
    int unsigned sh;
    logic [31:0] a;
    sh = eff_shift();
    k = $urandom_range(0, 99);
    if (k < 65 && live_chunks.size() != 0) begin
      a = slot(live_chunks[$urandom_range(0, live_chunks.size() - 1)]);
    end else if (k < 75) begin
      a = slot($urandom_range(0, MAX_CHUNKS_DEF - 1));
      if (sh > 0) a = a + $urandom_range(1, (1 << sh) - 1);
    end else if (k < 85) begin
      a = slot($urandom_range(0, MAX_CHUNKS_DEF - 1));
    end else if (k < 92) begin
      a = slot(eff_count() + $urandom_range(0, 3));
    end else begin
      a = $urandom();
    end
    return a;
  endfunction

  function automatic void queue_request(input logic mode, input logic [31:0] addr);
    req_t r;
    r.mode = mode;
    r.addr = addr;
    request_q = {request_q, r};
  endfunction

  task automatic program_pool(input logic [31:0] base, input logic [3:0] shift,
                              input logic [10:0] count);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_BASE;
    cfg_wdata <= base;
    @(posedge clk);
    cfg_index <= CFG_SHIFT;
    cfg_wdata <= {28'd0, shift};
    @(posedge clk);
    cfg_index <= CFG_COUNT;
    cfg_wdata <= {21'd0, count};
    @(posedge clk);
    cfg_we <= 1'b0;
    r_base = base;
    r_shift = shift;
    r_count = count;
  endtask

  // keeps only a couple of requests queued so frees track the live chunks
  task automatic random_phase(input int n_items, input int alloc_pct);
    logic mode;
    for (int i = 0; i < n_items; i++) begin
      while (request_q.size() >= 2) @(negedge clk);
      mode = ($urandom_range(0, 99) < alloc_pct) ? MODE_ALLOC : MODE_FREE;
      queue_request(mode, (mode == MODE_ALLOC) ? $urandom() : pick_free_addr());
    end
  endtask

  task automatic settle();
    while (request_q.size() != 0 || in_tvalid || grant_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) predict_grant(on_bus);
      if (!in_tvalid || in_tready) begin
        if (src_gap > 0) begin
          src_gap--;
          in_tvalid <= 1'b0;
        end else if (request_q.size() != 0) begin
          on_bus = request_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= on_bus.addr;
          in_tuser <= on_bus.mode;
          src_gap = src_idle_on ? pick_gap() : 0;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (hold_req) begin
        hold_req = 1'b0;
        snk_wait = HOLD_CYCLES;
      end
      if (out_tvalid && out_tready) begin
        n_checked++;
        if (grant_q.size() == 0) begin
          mismatches++;
          if (mismatches < 40)
            $display("%0t: result beat with nothing pending: expected none, got addr %h status %0d",
                     $time, out_tdata, out_tuser);
        end else begin
          seen = grant_q.pop_front();
          if (out_tdata !== seen.addr) begin
            mismatches++;
            if (mismatches < 40)
              $display("%0t: chunk_address expected %h got %h", $time, seen.addr, out_tdata);
          end
          if (out_tuser !== seen.st) begin
            mismatches++;
            if (mismatches < 40)
              $display("%0t: status expected %0d got %0d", $time, seen.st, out_tuser);
          end
        end
      end
      if (snk_wait > 0) begin
        snk_wait--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (snk_idle_on) snk_wait = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    for (int i = 0; i < MAX_CHUNKS_DEF; i++) in_use[i] = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // oversized shift and count at pool start, region wrapping past the top
    program_pool(32'hFFFF_F000, 4'd15, 11'd2047);
    @(negedge clk);
    queue_request(MODE_FREE, r_base);
    repeat (3) queue_request(MODE_ALLOC, $urandom());
    queue_request(MODE_FREE, slot(1022));
    queue_request(MODE_FREE, slot(1022));
    queue_request(MODE_FREE, slot(1021) + 32'd1);
    queue_request(MODE_FREE, slot(1021) + 32'h800);
    queue_request(MODE_FREE, r_base - 32'h1000);
    queue_request(MODE_FREE, slot(1024));
    queue_request(MODE_FREE, 32'hFFFF_FFFF);
    queue_request(MODE_FREE, 32'h0);
    queue_request(MODE_ALLOC, 32'hFFFF_FFFF);
    queue_request(MODE_FREE, slot(1023));
    queue_request(MODE_FREE, slot(1021));
    queue_request(MODE_ALLOC, '0);
    queue_request(MODE_ALLOC, '0);
    queue_request(MODE_FREE, slot(0));
    settle();

    // back to back, byte-sized chunks
    src_idle_on = 1'b0;
    snk_idle_on = 1'b0;
    program_pool($urandom(), 4'd0, 11'd1024);
    random_phase(450, 80);
    settle();

    // zero count: drain until the pool runs dry, every free refused
    src_idle_on = 1'b1;
    snk_idle_on = 1'b1;
    program_pool($urandom(), 4'd12, 11'd0);
    random_phase(spare_n + 60, 96);
    settle();

    // long receiver hold while requests keep coming
    hold_req = 1'b1;
    program_pool($urandom(), 4'($urandom_range(1, 11)), 11'd1024);
    random_phase(400, 45);
    settle();

    program_pool(32'h0, 4'd13, 11'd1);
    random_phase(300, 50);
    settle();

    program_pool(32'hFFFF_FFFF, RST_SHIFT, 11'($urandom_range(1, 1024)));
    random_phase(250, 50);
    settle();

    $display("Run covered %0d requests: %0d chunks handed out, %0d empty-pool replies,",
             n_granted + n_empty + n_returned + n_rejected, n_granted, n_empty);
    $display("  %0d frees taken, %0d frees refused; %0d result beats checked, %0d mismatches",
             n_returned, n_rejected, n_checked, mismatches);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
